[rtl/abd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abd_pkg
// Types, constants and tables shared by the ADPCM block decoder.
// ----------------------------------------------------------------------------
package abd_pkg;

  localparam int unsigned IDX_MAX_I = 88;

  localparam logic [6:0] IDX_MAX        = 7'd88;
  localparam logic [6:0] BLOCK_LEN_MONO = 7'd36;
  localparam logic [6:0] BLOCK_LEN_STER = 7'd72;
  localparam logic [6:0] HDR_LEN_MONO   = 7'd4;
  localparam logic [6:0] HDR_LEN_STER   = 7'd8;
  localparam logic [6:0] FRAME_FIRST    = 7'd0;
  localparam logic [6:0] FRAME_LAST     = 7'd64;

  localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;
  localparam logic signed [17:0] SAMPLE_MIN = -18'sd32768;

  // Header byte slots within a channel's 4-byte header
  localparam logic [1:0] HDR_PRED_LO = 2'd0;
  localparam logic [1:0] HDR_PRED_HI = 2'd1;
  localparam logic [1:0] HDR_INDEX   = 2'd2;
  localparam logic [1:0] HDR_SPARE   = 2'd3;

  // Words pushed into the result queue per accepted byte
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  localparam logic [14:0] IMA_STEP_SIZES [0:IDX_MAX_I] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
    15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
    15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
    15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
    15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
    15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
    15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  localparam logic signed [4:0] IDX_ADJ [0:7] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
  };

  // Decoded view of the current byte position
  typedef struct packed {
    logic       is_header;
    logic [1:0] hdr_slot;
    logic       chan;
    logic [6:0] frame;
    logic       last;
  } abd_pos_t;

  // One result word
  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic [6:0]         frame_index;
    logic               block_end;
    logic               item_end;
  } abd_result_t;

endpackage

[rtl/abd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abd_if
// Valid/ready channels: raw block bytes in, tagged PCM samples out.
// ----------------------------------------------------------------------------
interface abd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface abd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               channel;
  logic [6:0]         frame_index;
  logic               block_end;
  logic               item_end;

  modport source (output valid, output sample, output channel, output frame_index,
                  output block_end, output item_end, input ready);
  modport sink   (input valid, input sample, input channel, input frame_index,
                  input block_end, input item_end, output ready);
endinterface

[rtl/abd_nibble_dec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abd_nibble_dec
// One IMA ADPCM nibble update: saturated predictor and clamped step index.
// ----------------------------------------------------------------------------
module abd_nibble_dec
  import abd_pkg::*;
(
  input  logic signed [15:0] pred,
  input  logic [6:0]         step_idx,
  input  logic [3:0]         nibble,
  output logic signed [15:0] pred_next,
  output logic [6:0]         step_idx_next
);

  logic [6:0]         si;
  logic [14:0]        step;
  logic [16:0]        step_w;
  logic [16:0]        delta;
  logic signed [17:0] sum;
  logic signed [7:0]  ix;

  always_comb begin
    si     = (step_idx > IDX_MAX) ? IDX_MAX : step_idx;
    step   = IMA_STEP_SIZES[si];
    step_w = {2'b00, step};
    delta  = step_w >> 3;
    if (nibble[0]) begin
      delta = delta + (step_w >> 2);
    end
    if (nibble[1]) begin
      delta = delta + (step_w >> 1);
    end
    if (nibble[2]) begin
      delta = delta + step_w;
    end
    if (nibble[3]) begin
      sum = {{2{pred[15]}}, pred} - $signed({1'b0, delta});
    end else begin
      sum = {{2{pred[15]}}, pred} + $signed({1'b0, delta});
    end
    if (sum > SAMPLE_MAX) begin
      pred_next = SAMPLE_MAX[15:0];
    end else if (sum < SAMPLE_MIN) begin
      pred_next = SAMPLE_MIN[15:0];
    end else begin
      pred_next = sum[15:0];
    end

    ix = $signed({1'b0, si}) + 8'(IDX_ADJ[nibble[2:0]]);
    if (ix < 0) begin
      step_idx_next = '0;
    end else if (ix > $signed({1'b0, IDX_MAX})) begin
      step_idx_next = IDX_MAX;
    end else begin
      step_idx_next = ix[6:0];
    end
  end

endmodule

[rtl/abd_pos_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abd_pos_ctrl
// Maps the block byte position to header slot or data channel/frame.
// ----------------------------------------------------------------------------
module abd_pos_ctrl
  import abd_pkg::*;
(
  input  logic [1:0] channel_count,
  input  logic [6:0] byte_position,
  output abd_pos_t   pos_info,
  output logic [6:0] position_next
);

  logic       stereo;
  logic [6:0] block_len;
  logic [6:0] hdr_len;
  logic [6:0] pos;
  logic [6:0] pos_inc;
  logic [6:0] d;

  always_comb begin
    // zero acts as mono, three as stereo
    stereo    = channel_count[1];
    block_len = stereo ? BLOCK_LEN_STER : BLOCK_LEN_MONO;
    hdr_len   = stereo ? HDR_LEN_STER : HDR_LEN_MONO;
    // position left beyond a shorter block restarts the block
    pos       = (byte_position >= block_len) ? '0 : byte_position;
    pos_inc   = pos + 7'd1;
    d         = pos - hdr_len;

    pos_info.is_header = (pos < hdr_len);
    pos_info.hdr_slot  = pos[1:0];
    pos_info.last      = (pos_inc == block_len);
    position_next      = pos_info.last ? '0 : pos_inc;

    if (pos_info.is_header) begin
      pos_info.chan  = pos[2];
      pos_info.frame = FRAME_FIRST;
    end else if (stereo) begin
      // chunks of 4 bytes alternate between channels
      pos_info.chan  = d[2];
      pos_info.frame = 7'd1 + {1'b0, d[5:3], 3'b000} + {4'b0000, d[1:0], 1'b0};
    end else begin
      pos_info.chan  = 1'b0;
      pos_info.frame = 7'd1 + {d[5:0], 1'b0};
    end
  end

endmodule

[rtl/abd_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abd_out_queue
// Small result queue: up to two words in per cycle, one word out.
// ----------------------------------------------------------------------------
module abd_out_queue
  import abd_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  push,
  input  abd_result_t wr_word0,
  input  abd_result_t wr_word1,
  input  logic        pop,
  output logic        space_two,
  output logic        valid,
  output abd_result_t rd_word
);

  localparam int AW = (Depth > 2) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  abd_result_t   mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [AW-1:0] wr_ptr1;
  logic [AW-1:0] wr_ptr2;
  logic [AW-1:0] rd_ptr1;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign wr_ptr1   = ptr_inc(wr_ptr);
  assign wr_ptr2   = ptr_inc(wr_ptr1);
  assign rd_ptr1   = ptr_inc(rd_ptr);
  assign space_two = (count <= CW'(Depth - 2));
  assign valid     = (count != '0);
  assign rd_word   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push != PUSH_NONE) begin
      mem[wr_ptr] <= wr_word0;
    end
    if (push == PUSH_TWO) begin
      mem[wr_ptr1] <= wr_word1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push)
        PUSH_ONE: wr_ptr <= wr_ptr1;
        PUSH_TWO: wr_ptr <= wr_ptr2;
        default:  wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= rd_ptr1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(Depth))
    else $error("result queue count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push != PUSH_NONE |-> space_two)
    else $error("push into a queue without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !rst |=> count == $past(count) + CW'($past(push)) - CW'($past(pop)))
    else $error("result queue count does not follow push and pop");
`endif

endmodule

[rtl/adpcm_block_decoder.sv]
`timescale 1ns / 1ps
// Each result word is registered in the result queue and reaches sample_ch in order.
// Throughput: header bytes one per cycle while two words fit in the queue; data
//   bytes push two words each and are held back by the single-word output port.
// Reset (rst, synchronous): predictors and step indexes to zero, position to
//   the block header, channel_count to mono, result queue empty.
// ----------------------------------------------------------------------------
// adpcm_block_decoder
// IMA ADPCM block decoder, 36 bytes per channel, two samples per data byte.
// ----------------------------------------------------------------------------
module adpcm_block_decoder
  import abd_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_wr_data,
  abd_byte_if.sink     byte_ch,
  abd_sample_if.source sample_ch
);

  // Decoder state
  logic [1:0]         channel_count;
  logic signed [15:0] predictor [2];
  logic [6:0]         step_index [2];
  logic [6:0]         byte_position;

  abd_pos_t           pos_info;
  logic [6:0]         position_next;
  logic               accept;
  logic               space_two;
  logic [1:0]         push;
  abd_result_t        word0;
  abd_result_t        word1;
  abd_result_t        rd_word;
  logic               q_valid;
  logic               pop;

  // Channel selected by the current position
  logic signed [15:0] pred_cur;
  logic [6:0]         si_cur;
  logic signed [15:0] pred_mid;
  logic [6:0]         si_mid;
  logic signed [15:0] pred_end;
  logic [6:0]         si_end;
  logic [6:0]         hdr_index;

  abd_pos_ctrl u_pos (
    .channel_count (channel_count),
    .byte_position (byte_position),
    .pos_info      (pos_info),
    .position_next (position_next)
  );

  assign pred_cur = predictor[pos_info.chan];
  assign si_cur   = step_index[pos_info.chan];

  // Low nibble first, then the high nibble on its result
  abd_nibble_dec u_nib_lo (
    .pred          (pred_cur),
    .step_idx      (si_cur),
    .nibble        (byte_ch.data_byte[3:0]),
    .pred_next     (pred_mid),
    .step_idx_next (si_mid)
  );

  abd_nibble_dec u_nib_hi (
    .pred          (pred_mid),
    .step_idx      (si_mid),
    .nibble        (byte_ch.data_byte[7:4]),
    .pred_next     (pred_end),
    .step_idx_next (si_end)
  );

  // Header index byte is signed, clamped to the table range
  always_comb begin
    if (byte_ch.data_byte[7]) begin
      hdr_index = '0;
    end else if (byte_ch.data_byte[6:0] > IDX_MAX) begin
      hdr_index = IDX_MAX;
    end else begin
      hdr_index = byte_ch.data_byte[6:0];
    end
  end

  // The queue takes a byte only when two words fit
  assign byte_ch.ready = space_two;
  assign accept        = byte_ch.valid & space_two;

  always_comb begin
    push = PUSH_NONE;
    if (accept) begin
      if (!pos_info.is_header) begin
        push = PUSH_TWO;
      end else if (pos_info.hdr_slot == HDR_INDEX) begin
        push = PUSH_ONE;
      end
    end

    if (pos_info.is_header) begin
      // frame 0 carries the header predictor as is
      word0.sample      = pred_cur;
      word0.item_end    = 1'b1;
    end else begin
      word0.sample      = pred_mid;
      word0.item_end    = 1'b0;
    end
    word0.channel     = pos_info.chan;
    word0.frame_index = pos_info.frame;
    word0.block_end   = 1'b0;

    word1.sample      = pred_end;
    word1.channel     = pos_info.chan;
    word1.frame_index = pos_info.frame + 7'd1;
    word1.block_end   = pos_info.last;
    word1.item_end    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 2'd1;
      predictor[0]  <= '0;
      predictor[1]  <= '0;
      step_index[0] <= '0;
      step_index[1] <= '0;
      byte_position <= '0;
    end else begin
      if (cfg_wr_en) begin
        channel_count <= cfg_wr_data;
      end
      if (accept) begin
        byte_position <= position_next;
        if (pos_info.is_header) begin
          case (pos_info.hdr_slot)
            HDR_PRED_LO: predictor[pos_info.chan][7:0]  <= byte_ch.data_byte;
            HDR_PRED_HI: predictor[pos_info.chan][15:8] <= byte_ch.data_byte;
            HDR_INDEX:   step_index[pos_info.chan]      <= hdr_index;
            HDR_SPARE:   ;  // unused header byte
            default:     ;
          endcase
        end else begin
          predictor[pos_info.chan]  <= pred_end;
          step_index[pos_info.chan] <= si_end;
        end
      end
    end
  end

  // Result queue doubles as the output register
  assign pop = q_valid & sample_ch.ready;

  abd_out_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_word0  (word0),
    .wr_word1  (word1),
    .pop       (pop),
    .space_two (space_two),
    .valid     (q_valid),
    .rd_word   (rd_word)
  );

  assign sample_ch.valid       = q_valid;
  assign sample_ch.sample      = rd_word.sample;
  assign sample_ch.channel     = rd_word.channel;
  assign sample_ch.frame_index = rd_word.frame_index;
  assign sample_ch.block_end   = rd_word.block_end;
  assign sample_ch.item_end    = rd_word.item_end;

`ifndef SYNTH
  a_block_end_tag: assert property (@(posedge clk) disable iff (rst)
    sample_ch.valid && sample_ch.block_end |->
      sample_ch.item_end && sample_ch.frame_index == FRAME_LAST)
    else $error("block end word not tagged as the last frame");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    byte_position < BLOCK_LEN_STER)
    else $error("byte position beyond the longest block");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    step_index[0] <= IDX_MAX && step_index[1] <= IDX_MAX)
    else $error("step index beyond the table");

  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    sample_ch.valid |-> sample_ch.frame_index <= FRAME_LAST)
    else $error("frame index beyond the block");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ADPCM block decoder. Bytes go in over a
// valid/ready channel and a local decoder model predicts every tagged sample.
// Each word seen on the sample channel is checked against the oldest predicted
// sample. Directed header and saturation cases come first. Channel-count edge
// cases and an output stall follow. Random block streams run last, under
// three idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import abd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;     // bytes with no sample can still be in flight

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;

  abd_byte_if   byte_ch ();
  abd_sample_if sample_ch ();

  adpcm_block_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_ch     (byte_ch),
    .sample_ch   (sample_ch)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Decoder model: per-channel predictor and step index, block position and
  // the channel-count register. Updated at the edge where a byte is accepted.
  // --------------------------------------------------------------------------
  logic [15:0] pred_q [2];
  int          step_idx_q [2];
  int          blk_pos_q;
  logic [1:0]  chan_cfg_q;

  abd_result_t pending_samples [$];   // predicted samples, oldest first
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  // Idle shaping, in percent of cycles
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_req = 0;                   // receiver hold-off request, in cycles

  function automatic int chan_num();
    return (chan_cfg_q >= 2'd2) ? 2 : 1;
  endfunction

  // One IMA nibble: predictor saturates to 16 bits, index clamps to 0..88
  function automatic void apply_nibble(int c, logic [3:0] nib);
    int st, diff, pv, ix;
    st   = int'(IMA_STEP_SIZES[step_idx_q[c]]);
    diff = st >>> 3;
    if (nib[0]) diff += st >>> 2;
    if (nib[1]) diff += st >>> 1;
    if (nib[2]) diff += st;
    if (nib[3]) diff = -diff;
    pv = int'($signed(pred_q[c])) + diff;
    if (pv > 32767)  pv = 32767;
    if (pv < -32768) pv = -32768;
    pred_q[c] = pv[15:0];
    ix = step_idx_q[c] + int'(IDX_ADJ[nib[2:0]]);
    if (ix < 0)         ix = 0;
    if (ix > IDX_MAX_I) ix = IDX_MAX_I;
    step_idx_q[c] = ix;
  endfunction

  function automatic void push_sample(int c, int frame, bit bend, bit iend);
    abd_result_t r;
    r.sample      = pred_q[c];
    r.channel     = c[0];
    r.frame_index = frame[6:0];
    r.block_end   = bend;
    r.item_end    = iend;
    pending_samples.push_back(r);
  endfunction

  // Position of the next byte, with the wrap for a block that shrank under it
  function automatic int next_pos();
    int len;
    len = 36 * chan_num();
    return (blk_pos_q >= len) ? 0 : blk_pos_q;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int nch, len, p, c, d, chunk, chunk_ofs, frame, ix;
    logic [1:0] slot;
    nch = chan_num();
    len = 36 * nch;
    p = next_pos();
    blk_pos_q = (p + 1 >= len) ? 0 : p + 1;
    if (p < 4 * nch) begin
      c    = p >> 2;
      slot = p[1:0];
      case (slot)
        HDR_PRED_LO: pred_q[c][7:0]  = b;
        HDR_PRED_HI: pred_q[c][15:8] = b;
        HDR_INDEX: begin
          ix = int'($signed(b));
          if (ix < 0)         ix = 0;
          if (ix > IDX_MAX_I) ix = IDX_MAX_I;
          step_idx_q[c] = ix;
          push_sample(c, 0, 1'b0, 1'b1);
        end
        default: ;  // spare header byte carries nothing
      endcase
    end else begin
      d         = p - 4 * nch;
      chunk     = d / (4 * nch);
      chunk_ofs = d % (4 * nch);
      c         = chunk_ofs >> 2;
      frame     = 1 + chunk * 8 + (chunk_ofs & 3) * 2;
      apply_nibble(c, b[3:0]);
      push_sample(c, frame, 1'b0, 1'b0);
      apply_nibble(c, b[7:4]);
      push_sample(c, frame + 1, (p + 1 == len), 1'b1);
    end
  endfunction

  // Random byte, mostly well formed: index bytes usually land in 0..88
  function automatic logic [7:0] pick_byte();
    int p;
    p = next_pos();
    if (p < 4 * chan_num() && p[1:0] == HDR_INDEX && $urandom_range(0, 99) < 80)
      return 8'($urandom_range(0, IDX_MAX_I));
    return 8'($urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving tasks. Every task starts at a falling edge, so valid is
  // only ever changed once per step.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid     = 1'b1;
    byte_ch.data_byte = b;
    do @(posedge clk); while (!byte_ch.ready);
    decode_byte(b);
  endtask

  // Stop sending and let every predicted sample come out
  task automatic drain();
    @(negedge clk);
    byte_ch.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_channels(input logic [1:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(posedge clk);
    chan_cfg_q = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Mono header near full scale with an over-range index, then nibbles that
  // drive the predictor into both saturation limits and the index both ways.
  task automatic test_decode_extremes();
    logic [7:0] seq [$];
    seq = {8'hF0, 8'h7F, 8'h64, 8'hAA,            // pred 0x7FF0, index 100 -> 88
           8'h77, 8'h77, 8'hFF, 8'hFF, 8'h00,     // top clip, bottom clip
           8'h08, 8'h80, 8'h0F, 8'hF0};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Stereo stream stopped past the mono block length, then switched to mono:
  // the next byte opens a fresh block. Header with the most negative
  // predictor and a negative index follows.
  task automatic test_block_overrun();
    logic [7:0] seq [$];
    write_channels(2'd2);
    while (blk_pos_q < 40) send_byte(pick_byte());
    write_channels(2'd1);
    seq = {8'h00, 8'h80, 8'hFF, 8'h55, 8'h88, 8'h80, 8'h8F, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);
    drain();
  endtask

  // Receiver holds off long enough for the decoder to fill and stall input,
  // then the sender pauses until everything has come out.
  task automatic test_output_stall();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req = 80;
    repeat (30) send_byte(pick_byte());
    drain();
  endtask

  task automatic test_random_stream(input int n, input logic [1:0] chans,
                                    input int src_pct, input int snk_pct);
    write_channels(chans);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (n) send_byte(pick_byte());
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, or a counted hold-off when one is requested
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    sample_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        sample_ch.ready = 1'b0;
        hold_left--;
      end else begin
        sample_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample checker: every accepted word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    abd_result_t got, want;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      got.sample      = sample_ch.sample;
      got.channel     = sample_ch.channel;
      got.frame_index = sample_ch.frame_index;
      got.block_end   = sample_ch.block_end;
      got.item_end    = sample_ch.item_end;
      if (pending_samples.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected sample %0d ch %0d frame %0d bend %0b iend %0b",
                 $time, got.sample, got.channel, got.frame_index, got.block_end,
                 got.item_end);
      end else begin
        want = pending_samples.pop_front();
        if (got.sample !== want.sample || got.channel !== want.channel ||
            got.frame_index !== want.frame_index || got.block_end !== want.block_end ||
            got.item_end !== want.item_end) begin
          err_cnt++;
          $display("%0t: mismatch exp %0d ch %0d frame %0d bend %0b iend %0b",
                   $time, want.sample, want.channel, want.frame_index, want.block_end,
                   want.item_end);
          $display("%0t:          got %0d ch %0d frame %0d bend %0b iend %0b",
                   $time, got.sample, got.channel, got.frame_index, got.block_end,
                   got.item_end);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'd0;
    pred_q[0] = 16'd0;
    pred_q[1] = 16'd0;
    step_idx_q[0] = 0;
    step_idx_q[1] = 0;
    blk_pos_q  = 0;
    chan_cfg_q = 2'd1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_decode_extremes();
    test_block_overrun();
    test_output_stall();
    // Channel counts change at phase edges, often mid-block
    test_random_stream(170, 2'd2, 30, 66);
    test_random_stream(170, 2'd1, 66, 30);
    test_random_stream(80, 2'd3, 0, 0);
    test_random_stream(80, 2'd0, 0, 0);
    drain();
    repeat (10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[adpcm_block_decoder.f]
rtl/abd_pkg.sv
rtl/abd_if.sv
rtl/abd_nibble_dec.sv
rtl/abd_pos_ctrl.sv
rtl/abd_out_queue.sv
rtl/adpcm_block_decoder.sv
dv/tb.sv
